// ===== hdl/lru_key_table_with_hit_counters_unit_assert.svh =====
// ---------------------------------------------------------------------------
// lru key table assertion macros
// concurrent assertion shorthands clocked on aclk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_TABLE_WITH_HIT_COUNTERS_UNIT_ASSERT_SVH
`define LRU_KEY_TABLE_WITH_HIT_COUNTERS_UNIT_ASSERT_SVH

// same-cycle implication
`define LKT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LKT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lkt_pkg.sv =====
// ---------------------------------------------------------------------------
// lru key table package
// codes, field widths, memory entry types and sequencer states
// ---------------------------------------------------------------------------
`default_nettype none

package lkt_pkg;

    localparam int KEY_W      = 32;
    localparam int ATTR_W     = 16;
    localparam int CNT_W      = 32;
    localparam int TICK_W     = 48;
    localparam int SLOT_IDX_W = 6;
    localparam int COL_IDX_W  = 4;

    localparam logic [1:0] CMD_BEGIN     = 2'd0;
    localparam logic [1:0] CMD_PREDICATE = 2'd1;
    localparam logic [1:0] CMD_READ      = 2'd2;

    localparam logic [1:0] OP_EQUAL = 2'd0;
    localparam logic [1:0] OP_RANGE = 2'd1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_NO_SCAN = 2'd3;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN_SLOT,
        FSM_WIPE,
        FSM_SCAN_COL,
        FSM_READ,
        FSM_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TICK_W-1:0] tick;
    } slot_entry_t;

    typedef struct packed {
        logic signed [ATTR_W-1:0] attr;
        logic [CNT_W-1:0]         eq_count;
        logic [CNT_W-1:0]         rg_count;
    } col_entry_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [SLOT_IDX_W-1:0]    slot_index;
        logic [COL_IDX_W-1:0]     column_index;
        logic                     was_new_entry;
        logic [KEY_W-1:0]         entry_key;
        logic signed [ATTR_W-1:0] entry_attribute;
        logic [CNT_W-1:0]         equality_count;
        logic [CNT_W-1:0]         range_count;
        logic [TICK_W-1:0]        entry_tick;
    } beat_t;

endpackage

`default_nettype wire

// ===== hdl/lru_key_table_with_hit_counters_unit.sv =====
// ---------------------------------------------------------------------------
// lru key table with hit counters
// fully associative key table with lru replacement and per-entry column
// hit counters, held in a slot memory and a column memory
// ---------------------------------------------------------------------------
// Every command gives exactly one result beat. The table lives in two
// single-port-write memories with a registered read, and a sequencer
// walks them one entry a cycle, so one command is worked on at a time.
// A begin command walks the slot memory, and on a miss it also wipes the
// column row of a newly taken entry. A predicate walks the current
// entry's column row up to a hit. A read fetches one slot and one column
// entry; an invalid command goes straight to its result. After reset a
// clearing pass zeroes both memories before the first beat is taken.
// A finished result waits in an output register, so the next command is
// accepted while the previous result is still stalled.
`default_nettype none
`include "lru_key_table_with_hit_counters_unit_assert.svh"

module lru_key_table_with_hit_counters_unit #(
    parameter int TABLE_SLOTS  = 64,
    parameter int COLUMN_SLOTS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    input  wire logic [31:0]        s_relation_key,
    input  wire logic signed [15:0] s_attribute_number,
    input  wire logic [1:0]         s_op_kind,
    input  wire logic [5:0]         s_read_table_index,
    input  wire logic [3:0]         s_read_column_index,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [5:0]              m_slot_index,
    output logic [3:0]              m_column_index,
    output logic                    m_was_new_entry,
    output logic [31:0]             m_entry_key,
    output logic signed [15:0]      m_entry_attribute,
    output logic [31:0]             m_equality_count,
    output logic [31:0]             m_range_count,
    output logic [47:0]             m_entry_tick
);

    localparam int TW        = $clog2(TABLE_SLOTS);
    localparam int CW        = (COLUMN_SLOTS > 1) ? $clog2(COLUMN_SLOTS) : 1;
    localparam int AW        = TW + CW;
    localparam int COL_DEPTH = TABLE_SLOTS * (2 ** CW);
    localparam int SCW       = TW + 1;
    localparam int CCW       = CW + 1;

    // memories
    lkt_pkg::slot_entry_t slot_mem [TABLE_SLOTS];
    lkt_pkg::col_entry_t  col_mem  [COL_DEPTH];

    lkt_pkg::slot_entry_t slot_rd_reg;
    lkt_pkg::col_entry_t  col_rd_reg;

    logic                 slot_rd_en;
    logic [TW-1:0]        slot_rd_addr;
    logic                 slot_wr_en;
    logic [TW-1:0]        slot_wr_addr;
    lkt_pkg::slot_entry_t slot_wr_data;

    logic                 col_rd_en;
    logic [AW-1:0]        col_rd_addr;
    logic                 col_wr_en;
    logic [AW-1:0]        col_wr_addr;
    lkt_pkg::col_entry_t  col_wr_data;

    // sequencer and state
    lkt_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [SCW-1:0]  scnt_reg, scnt_next;
    logic [CCW-1:0]  ccnt_reg, ccnt_next;
    logic            pend_reg, pend_next;
    logic [TW-1:0]   spidx_reg, spidx_next;
    logic [CW-1:0]   cpidx_reg, cpidx_next;
    logic            have_empty_reg, have_empty_next;
    logic [TW-1:0]   empty_reg, empty_next;
    logic [CW-1:0]   cempty_reg, cempty_next;
    logic            lru_any_reg, lru_any_next;
    logic [TW-1:0]   lru_reg, lru_next;
    logic [47:0]     lru_tick_reg, lru_tick_next;
    logic [TW-1:0]   sel_reg, sel_next;
    logic [CW-1:0]   csel_reg, csel_next;

    logic [31:0]        req_key_reg, req_key_next;
    logic signed [15:0] req_attr_reg, req_attr_next;
    logic [1:0]         req_op_reg, req_op_next;

    logic [47:0]     tick_reg, tick_next;
    logic [47:0]     tick_inc;
    logic            cur_valid_reg, cur_valid_next;
    logic [TW-1:0]   cur_slot_reg, cur_slot_next;
    logic [31:0]     cur_key_reg, cur_key_next;
    logic [47:0]     cur_tick_reg, cur_tick_next;

    lkt_pkg::beat_t  res_reg, res_next;
    lkt_pkg::beat_t  m_beat_reg, m_beat_next;
    logic            m_valid_reg, m_valid_next;

    logic            col_hit;
    logic [CW-1:0]   col_k;
    logic [31:0]     base_eq;
    logic [31:0]     base_rg;
    logic [31:0]     new_eq;
    logic [31:0]     new_rg;

    assign tick_inc = tick_reg + 48'd1;

    always_ff @(posedge aclk) begin
        if (slot_rd_en) begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
        if (slot_wr_en) begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (col_rd_en) begin
            col_rd_reg <= col_mem[col_rd_addr];
        end
        if (col_wr_en) begin
            col_mem[col_wr_addr] <= col_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lkt_pkg::FSM_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            tick_reg      <= '0;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            tick_reg      <= tick_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scnt_reg       <= scnt_next;
        ccnt_reg       <= ccnt_next;
        spidx_reg      <= spidx_next;
        cpidx_reg      <= cpidx_next;
        have_empty_reg <= have_empty_next;
        empty_reg      <= empty_next;
        cempty_reg     <= cempty_next;
        lru_any_reg    <= lru_any_next;
        lru_reg        <= lru_next;
        lru_tick_reg   <= lru_tick_next;
        sel_reg        <= sel_next;
        csel_reg       <= csel_next;
        req_key_reg    <= req_key_next;
        req_attr_reg   <= req_attr_next;
        req_op_reg     <= req_op_next;
        cur_key_reg    <= cur_key_next;
        cur_tick_reg   <= cur_tick_next;
        res_reg        <= res_next;
        m_beat_reg     <= m_beat_next;
    end

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        scnt_next       = scnt_reg;
        ccnt_next       = ccnt_reg;
        pend_next       = 1'b0;
        spidx_next      = spidx_reg;
        cpidx_next      = cpidx_reg;
        have_empty_next = have_empty_reg;
        empty_next      = empty_reg;
        cempty_next     = cempty_reg;
        lru_any_next    = lru_any_reg;
        lru_next        = lru_reg;
        lru_tick_next   = lru_tick_reg;
        sel_next        = sel_reg;
        csel_next       = csel_reg;
        req_key_next    = req_key_reg;
        req_attr_next   = req_attr_reg;
        req_op_next     = req_op_reg;
        tick_next       = tick_reg;
        cur_valid_next  = cur_valid_reg;
        cur_slot_next   = cur_slot_reg;
        cur_key_next    = cur_key_reg;
        cur_tick_next   = cur_tick_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_beat_next     = m_beat_reg;

        s_ready      = 1'b0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = scnt_reg[TW-1:0];
        slot_wr_en   = 1'b0;
        slot_wr_addr = sel_reg;
        slot_wr_data = '0;
        col_rd_en    = 1'b0;
        col_rd_addr  = {cur_slot_reg, ccnt_reg[CW-1:0]};
        col_wr_en    = 1'b0;
        col_wr_addr  = {sel_reg, ccnt_reg[CW-1:0]};
        col_wr_data  = '0;

        col_hit = 1'b0;
        col_k   = cpidx_reg;
        base_eq = '0;
        base_rg = '0;
        new_eq  = '0;
        new_rg  = '0;

        case (state_reg)
            lkt_pkg::FSM_CLEAR: begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = clr_reg[AW-1:CW];
                col_wr_en    = 1'b1;
                col_wr_addr  = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == AW'(COL_DEPTH - 1)) begin
                    state_next = lkt_pkg::FSM_IDLE;
                end
            end

            lkt_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_key_next  = s_relation_key;
                    req_attr_next = s_attribute_number;
                    req_op_next   = s_op_kind;
                    res_next      = '0;
                    state_next    = lkt_pkg::FSM_DONE;
                    case (s_cmd)
                        lkt_pkg::CMD_BEGIN: begin
                            if (s_relation_key == '0) begin
                                cur_valid_next  = 1'b0;
                                res_next.status = lkt_pkg::STATUS_INVALID;
                            end else begin
                                scnt_next       = '0;
                                have_empty_next = 1'b0;
                                lru_any_next    = 1'b0;
                                state_next      = lkt_pkg::FSM_SCAN_SLOT;
                            end
                        end
                        lkt_pkg::CMD_PREDICATE: begin
                            if (!cur_valid_reg) begin
                                res_next.status = lkt_pkg::STATUS_NO_SCAN;
                            end else if (s_attribute_number[15]
                                         || s_attribute_number == '0) begin
                                res_next.status     = lkt_pkg::STATUS_INVALID;
                                res_next.slot_index = 6'(cur_slot_reg);
                                res_next.entry_key  = cur_key_reg;
                                res_next.entry_tick = cur_tick_reg;
                            end else begin
                                ccnt_next       = '0;
                                have_empty_next = 1'b0;
                                state_next      = lkt_pkg::FSM_SCAN_COL;
                            end
                        end
                        lkt_pkg::CMD_READ: begin
                            if (32'(s_read_table_index) >= TABLE_SLOTS
                                || 32'(s_read_column_index) >= COLUMN_SLOTS) begin
                                res_next.status = lkt_pkg::STATUS_INVALID;
                            end else begin
                                sel_next     = TW'(s_read_table_index);
                                csel_next    = CW'(s_read_column_index);
                                slot_rd_en   = 1'b1;
                                slot_rd_addr = TW'(s_read_table_index);
                                col_rd_en    = 1'b1;
                                col_rd_addr  = {TW'(s_read_table_index),
                                                CW'(s_read_column_index)};
                                state_next   = lkt_pkg::FSM_READ;
                            end
                        end
                        default: begin
                            res_next.status = lkt_pkg::STATUS_INVALID;
                        end
                    endcase
                end
            end

            lkt_pkg::FSM_SCAN_SLOT: begin
                if (scnt_reg < SCW'(TABLE_SLOTS)) begin
                    slot_rd_en = 1'b1;
                    scnt_next  = scnt_reg + 1'b1;
                    pend_next  = 1'b1;
                    spidx_next = scnt_reg[TW-1:0];
                end
                if (pend_reg) begin
                    if (slot_rd_reg.key == req_key_reg) begin
                        // key present: restamp only
                        slot_wr_en          = 1'b1;
                        slot_wr_addr        = spidx_reg;
                        slot_wr_data.key    = req_key_reg;
                        slot_wr_data.tick   = tick_inc;
                        tick_next           = tick_inc;
                        cur_valid_next      = 1'b1;
                        cur_slot_next       = spidx_reg;
                        cur_key_next        = req_key_reg;
                        cur_tick_next       = tick_inc;
                        res_next            = '0;
                        res_next.status     = lkt_pkg::STATUS_OK;
                        res_next.slot_index = 6'(spidx_reg);
                        res_next.entry_key  = req_key_reg;
                        res_next.entry_tick = tick_inc;
                        pend_next           = 1'b0;
                        state_next          = lkt_pkg::FSM_DONE;
                    end else begin
                        if (slot_rd_reg.key == '0 && !have_empty_reg) begin
                            have_empty_next = 1'b1;
                            empty_next      = spidx_reg;
                        end
                        // first minimum stamp
                        if (!lru_any_reg || slot_rd_reg.tick < lru_tick_reg) begin
                            lru_any_next  = 1'b1;
                            lru_next      = spidx_reg;
                            lru_tick_next = slot_rd_reg.tick;
                        end
                        if (spidx_reg == TW'(TABLE_SLOTS - 1)) begin
                            sel_next   = have_empty_next ? empty_next : lru_next;
                            ccnt_next  = '0;
                            pend_next  = 1'b0;
                            state_next = lkt_pkg::FSM_WIPE;
                        end
                    end
                end
            end

            lkt_pkg::FSM_WIPE: begin
                col_wr_en   = 1'b1;
                col_wr_addr = {sel_reg, ccnt_reg[CW-1:0]};
                ccnt_next   = ccnt_reg + 1'b1;
                if (ccnt_reg[CW-1:0] == CW'(COLUMN_SLOTS - 1)) begin
                    slot_wr_en             = 1'b1;
                    slot_wr_addr           = sel_reg;
                    slot_wr_data.key       = req_key_reg;
                    slot_wr_data.tick      = tick_inc;
                    tick_next              = tick_inc;
                    cur_valid_next         = 1'b1;
                    cur_slot_next          = sel_reg;
                    cur_key_next           = req_key_reg;
                    cur_tick_next          = tick_inc;
                    res_next               = '0;
                    res_next.status        = lkt_pkg::STATUS_OK;
                    res_next.slot_index    = 6'(sel_reg);
                    res_next.was_new_entry = 1'b1;
                    res_next.entry_key     = req_key_reg;
                    res_next.entry_tick    = tick_inc;
                    state_next             = lkt_pkg::FSM_DONE;
                end
            end

            lkt_pkg::FSM_SCAN_COL: begin
                if (ccnt_reg < CCW'(COLUMN_SLOTS)) begin
                    col_rd_en   = 1'b1;
                    col_rd_addr = {cur_slot_reg, ccnt_reg[CW-1:0]};
                    ccnt_next   = ccnt_reg + 1'b1;
                    pend_next   = 1'b1;
                    cpidx_next  = ccnt_reg[CW-1:0];
                end
                if (pend_reg) begin
                    col_hit = (col_rd_reg.attr == req_attr_reg);
                    if (!col_hit && col_rd_reg.attr == '0 && !have_empty_reg) begin
                        have_empty_next = 1'b1;
                        cempty_next     = cpidx_reg;
                    end
                    if (col_hit || cpidx_reg == CW'(COLUMN_SLOTS - 1)) begin
                        pend_next  = 1'b0;
                        state_next = lkt_pkg::FSM_DONE;
                        res_next   = '0;
                        res_next.slot_index = 6'(cur_slot_reg);
                        res_next.entry_key  = cur_key_reg;
                        res_next.entry_tick = cur_tick_reg;
                        if (col_hit || have_empty_next) begin
                            // an empty column slot always holds zero counters
                            col_k   = col_hit ? cpidx_reg : cempty_next;
                            base_eq = col_hit ? col_rd_reg.eq_count : '0;
                            base_rg = col_hit ? col_rd_reg.rg_count : '0;
                            new_eq  = base_eq;
                            new_rg  = base_rg;
                            if (req_op_reg == lkt_pkg::OP_EQUAL && base_eq != '1) begin
                                new_eq = base_eq + 32'd1;
                            end
                            if (req_op_reg == lkt_pkg::OP_RANGE && base_rg != '1) begin
                                new_rg = base_rg + 32'd1;
                            end
                            col_wr_en                = 1'b1;
                            col_wr_addr              = {cur_slot_reg, col_k};
                            col_wr_data.attr         = req_attr_reg;
                            col_wr_data.eq_count     = new_eq;
                            col_wr_data.rg_count     = new_rg;
                            res_next.status          = lkt_pkg::STATUS_OK;
                            res_next.column_index    = 4'(col_k);
                            res_next.entry_attribute = req_attr_reg;
                            res_next.equality_count  = new_eq;
                            res_next.range_count     = new_rg;
                        end else begin
                            res_next.status = lkt_pkg::STATUS_FULL;
                        end
                    end
                end
            end

            lkt_pkg::FSM_READ: begin
                res_next                 = '0;
                res_next.status          = lkt_pkg::STATUS_OK;
                res_next.slot_index      = 6'(sel_reg);
                res_next.column_index    = 4'(csel_reg);
                res_next.entry_key       = slot_rd_reg.key;
                res_next.entry_tick      = slot_rd_reg.tick;
                res_next.entry_attribute = col_rd_reg.attr;
                res_next.equality_count  = col_rd_reg.eq_count;
                res_next.range_count     = col_rd_reg.rg_count;
                state_next               = lkt_pkg::FSM_DONE;
            end

            lkt_pkg::FSM_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_beat_next  = res_reg;
                    state_next   = lkt_pkg::FSM_IDLE;
                end
            end

            default: begin
                state_next = lkt_pkg::FSM_IDLE;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_beat_reg.status;
    assign m_slot_index      = m_beat_reg.slot_index;
    assign m_column_index    = m_beat_reg.column_index;
    assign m_was_new_entry   = m_beat_reg.was_new_entry;
    assign m_entry_key       = m_beat_reg.entry_key;
    assign m_entry_attribute = m_beat_reg.entry_attribute;
    assign m_equality_count  = m_beat_reg.equality_count;
    assign m_range_count     = m_beat_reg.range_count;
    assign m_entry_tick      = m_beat_reg.entry_tick;

    `LKT_ASSERT_IMP(a_busy_not_ready, state_reg != lkt_pkg::FSM_IDLE, !s_ready,
        "input beat taken while the sequencer is busy")
    `LKT_ASSERT_IMP(a_col_scan_needs_scan, state_reg == lkt_pkg::FSM_SCAN_COL,
        cur_valid_reg, "column walk without a current entry")
    `LKT_ASSERT_NXT(a_done_loads_output,
        state_reg == lkt_pkg::FSM_DONE && (!m_valid_reg || m_ready),
        m_valid_reg && state_reg == lkt_pkg::FSM_IDLE, "result beat not loaded")
    `LKT_ASSERT_IMP(a_tick_only_with_stamp, tick_next != tick_reg,
        slot_wr_en && slot_wr_data.tick == tick_next && state_reg != lkt_pkg::FSM_CLEAR,
        "global tick moved without stamping a slot")

endmodule

`default_nettype wire
